// File: hdl/bitmap_pixel_stream_decoder_defines.svh
// ----------------------------------------------------------------------------
// Bitmap pixel stream decoder: assertion macros
// Shared property wrappers, clocked on the rising edge, held off during reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PIXEL_STREAM_DECODER_DEFINES_SVH
`define BITMAP_PIXEL_STREAM_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/bpsd_pkg.sv
// ----------------------------------------------------------------------------
// bpsd_pkg
// Types, constants and helper functions of the bitmap pixel stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bpsd_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int CNT_W     = $clog2(MAX_DIM);
	localparam int PAL_DEPTH = 256;
	localparam int PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
	localparam int PAL_DW    = 24;

	typedef enum logic [1:0] {
		FMT_IDX8   = 2'd0,
		FMT_RGB555 = 2'd1,
		FMT_RGB24  = 2'd2,
		FMT_RGB32  = 2'd3
	} fmt_t;

	typedef enum logic [1:0] {
		KIND_PIXEL   = 2'd0,
		KIND_PALETTE = 2'd1,
		KIND_START   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_FORMAT = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		fmt_t               fmt;
		logic [12:0]        width;
		logic signed [13:0] height;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [11:0] row;
		logic [11:0] column;
		logic        frame_done;
	} px_t;

	// Pixel leaving the counter stage; colors come from the palette when use_pal.
	typedef struct packed {
		px_t  pix;
		logic use_pal;
		logic pal_black;
	} px_stage_t;

	typedef struct packed {
		logic       finished;
		logic [1:0] byte_cnt;
		logic [1:0] pad_cnt;
	} stat_t;

	// floor(v * 255 / 31)
	localparam logic [7:0] SCALE5_LUT [32] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
		8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
		8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
		8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
	};

	function automatic logic [7:0] scale5(input logic [4:0] v);
		return SCALE5_LUT[v];
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [13:0] v);
		logic [DIM_W-1:0] r;
		if (v == 14'd0) begin
			r = DIM_W'(1);
		end else if ({18'd0, v} > 32'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/bpsd_in_if.sv
// ----------------------------------------------------------------------------
// bpsd_in_if
// Input channel: pixel bytes, palette writes and image starts.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpsd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [7:0]  palette_index;
	logic [31:0] palette_word;

	modport source (output valid, kind, data_byte, palette_index, palette_word,
		input ready);
	modport sink (input valid, kind, data_byte, palette_index, palette_word,
		output ready);
endinterface

`default_nettype wire

// File: hdl/bpsd_out_if.sv
// ----------------------------------------------------------------------------
// bpsd_out_if
// Output channel: one decoded pixel with its position.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpsd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [11:0] row;
	logic [11:0] column;
	logic        frame_done;

	modport source (output valid, red, green, blue, row, column, frame_done,
		input ready);
	modport sink (input valid, red, green, blue, row, column, frame_done,
		output ready);
endinterface

`default_nettype wire

// File: hdl/bpsd_ram.sv
// ----------------------------------------------------------------------------
// bpsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/bpsd_regs.sv
// ----------------------------------------------------------------------------
// bpsd_regs
// APB configuration registers: pixel format, image width, image height.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsd_regs import bpsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fmt    <= FMT_RGB24;
			cfg_q.width  <= 13'd1;
			cfg_q.height <= 14'sd1;
		end else if (wr_en) begin
			case (idx)
				REG_FORMAT: cfg_q.fmt    <= fmt_t'(pwdata[1:0]);
				REG_WIDTH:  cfg_q.width  <= pwdata[12:0];
				REG_HEIGHT: cfg_q.height <= pwdata[13:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FORMAT: prdata = {30'd0, cfg_q.fmt};
			REG_WIDTH:  prdata = {19'd0, cfg_q.width};
			REG_HEIGHT: prdata = {18'd0, cfg_q.height};
			default:    prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/bpsd_ctrl.sv
// ----------------------------------------------------------------------------
// bpsd_ctrl
// Byte assembly, pad skipping, column/row counting and palette port control.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsd_ctrl import bpsd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [1:0]        kind,
	input  wire logic [7:0]        data_byte,
	input  wire logic [7:0]        palette_index,
	input  wire logic [31:0]       palette_word,
	input  wire cfg_t              cfg,
	output logic                   px_valid,
	output px_stage_t              px,
	output logic                   pal_we,
	output logic [PAL_AW-1:0]      pal_waddr,
	output logic [PAL_DW-1:0]      pal_wdata,
	output logic                   pal_re,
	output logic [PAL_AW-1:0]      pal_raddr,
	output stat_t                  stat
);

	logic [23:0]      acc_q;
	logic [1:0]       byte_q;
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [1:0]       pad_q;
	logic             fin_q;

	logic             is_pix;
	logic             complete;
	logic             top_down;
	logic [13:0]      hmag;
	logic [DIM_W-1:0] width_c;
	logic [DIM_W-1:0] rows_c;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;
	logic             row_end;
	logic             img_end;
	logic [1:0]       bpp;
	logic [1:0]       pad_new;
	logic [15:0]      w16;

	assign is_pix   = fire && (kind == KIND_PIXEL) && !fin_q;
	assign complete = is_pix && (pad_q == 2'd0) && (byte_q >= cfg.fmt);

	assign top_down = cfg.height[13];
	assign hmag     = top_down ? 14'(14'd0 - cfg.height) : cfg.height;
	assign width_c  = clamp_dim({1'b0, cfg.width});
	assign rows_c   = clamp_dim(hmag);
	assign col_inc  = {1'b0, col_q} + DIM_W'(1);
	assign row_inc  = {1'b0, row_q} + DIM_W'(1);
	assign row_end  = col_inc >= width_c;
	assign img_end  = row_inc >= rows_c;
	assign bpp      = 2'(cfg.fmt) + 2'd1;
	assign pad_new  = 2'd0 - 2'(width_c[1:0] * bpp);
	assign w16      = {data_byte, acc_q[7:0]};

	// Palette port: writes at transfer, lookups for completed indexed pixels.
	assign pal_we    = fire && (kind == KIND_PALETTE)
		&& ({1'b0, palette_index} < 9'(PAL_DEPTH));
	assign pal_waddr = PAL_AW'(palette_index);
	assign pal_wdata = palette_word[PAL_DW-1:0];
	assign pal_re    = complete && (cfg.fmt == FMT_IDX8);
	assign pal_raddr = PAL_AW'(data_byte);

	assign px_valid = complete;

	always_comb begin
		px = '0;
		px.pal_black = ({1'b0, data_byte} >= 9'(PAL_DEPTH));
		case (cfg.fmt)
			FMT_IDX8: begin
				px.use_pal = 1'b1;
			end
			FMT_RGB555: begin
				px.pix.red   = scale5(w16[14:10]);
				px.pix.green = scale5(w16[9:5]);
				px.pix.blue  = scale5(w16[4:0]);
			end
			FMT_RGB24: begin
				px.pix.red   = data_byte;
				px.pix.green = acc_q[15:8];
				px.pix.blue  = acc_q[7:0];
			end
			default: begin
				// 32-bit: the completing byte is the unused fourth one
				px.pix.red   = acc_q[23:16];
				px.pix.green = acc_q[15:8];
				px.pix.blue  = acc_q[7:0];
			end
		endcase
		if (top_down) begin
			px.pix.row = row_q;
		end else if ({1'b0, row_q} < rows_c) begin
			px.pix.row = CNT_W'(rows_c - DIM_W'(1) - {1'b0, row_q});
		end else begin
			px.pix.row = '0;
		end
		px.pix.column     = col_q;
		px.pix.frame_done = row_end && img_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			byte_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
			pad_q  <= '0;
			fin_q  <= 1'b0;
		end else if (fire && (kind == KIND_START)) begin
			acc_q  <= '0;
			byte_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
			pad_q  <= '0;
			fin_q  <= 1'b0;
		end else if (is_pix) begin
			if (pad_q != 2'd0) begin
				pad_q <= pad_q - 2'd1;
			end else if (!complete) begin
				acc_q  <= acc_q | (24'(data_byte) << {byte_q, 3'b000});
				byte_q <= byte_q + 2'd1;
			end else begin
				acc_q  <= '0;
				byte_q <= '0;
				if (row_end) begin
					col_q <= '0;
					if (img_end) begin
						fin_q <= 1'b1;
						pad_q <= '0;
					end else begin
						row_q <= row_q + CNT_W'(1);
						pad_q <= pad_new;
					end
				end else begin
					col_q <= col_q + CNT_W'(1);
				end
			end
		end
	end

	assign stat.finished = fin_q;
	assign stat.byte_cnt = byte_q;
	assign stat.pad_cnt  = pad_q;

endmodule

`default_nettype wire

// File: hdl/bpsd_outq.sv
// ----------------------------------------------------------------------------
// bpsd_outq
// Palette read stage and output register; read stage waits for output room.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsd_outq import bpsd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                px_valid,
	input  wire px_stage_t           px,
	input  wire logic [PAL_DW-1:0]   pal_rdata,
	output logic                     in_ready,
	output logic                     s1_busy,
	bpsd_out_if.source               pix_out
);

	logic      s1_v_s1;
	px_stage_t px_s1;
	logic      out_v_q;
	px_t       out_q;
	logic      out_room;
	logic      s1_adv;
	px_t       merged;

	assign out_room = !out_v_q || pix_out.ready;
	assign s1_adv   = s1_v_s1 && out_room;
	assign in_ready = !s1_v_s1 || out_room;
	assign s1_busy  = s1_v_s1;

	// RAM data holds while stalled: a new lookup issues only on a transfer.
	always_comb begin
		merged = px_s1.pix;
		if (px_s1.use_pal) begin
			if (px_s1.pal_black) begin
				merged.red   = 8'd0;
				merged.green = 8'd0;
				merged.blue  = 8'd0;
			end else begin
				merged.red   = pal_rdata[23:16];
				merged.green = pal_rdata[15:8];
				merged.blue  = pal_rdata[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_v_s1 <= px_valid;
			end
			if (out_room) begin
				out_v_q <= s1_v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && px_valid) begin
			px_s1 <= px;
		end
		if (s1_adv) begin
			out_q <= merged;
		end
	end

	assign pix_out.valid      = out_v_q;
	assign pix_out.red        = out_q.red;
	assign pix_out.green      = out_q.green;
	assign pix_out.blue       = out_q.blue;
	assign pix_out.row        = out_q.row;
	assign pix_out.column     = out_q.column;
	assign pix_out.frame_done = out_q.frame_done;

endmodule

`default_nettype wire

// File: hdl/bitmap_pixel_stream_decoder.sv
// ----------------------------------------------------------------------------
// bitmap_pixel_stream_decoder
// Decodes bitmap pixel bytes (indexed, RGB555, 24-bit, 32-bit) into RGB pixels.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  pix_in    in   valid/ready    kind, data_byte, palette_index, palette_word
//  pix_out   out  valid/ready    red, green, blue, row, column, frame_done
//  apb       in   psel/penable   paddr[3:0], pwdata, prdata (pready tied high)
//
// One transfer per cycle on pix_in while pix_in.ready is high; after its last
// byte a pixel passes the registered palette RAM read, then the output reg.
// Reset clears counters and handshake state; palette RAM is not cleared and
// needs no sweep, entries are undefined until written.
// A stalled pix_out holds two pixels (read stage + output reg) before
// pix_in.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_pixel_stream_decoder_defines.svh"

module bitmap_pixel_stream_decoder import bpsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	bpsd_in_if.sink          pix_in,
	bpsd_out_if.source       pix_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	cfg_t               cfg;
	logic               fire;
	logic               in_ready;
	logic               s1_busy;
	logic               px_valid;
	px_stage_t          px;
	logic               pal_we;
	logic [PAL_AW-1:0]  pal_waddr;
	logic [PAL_DW-1:0]  pal_wdata;
	logic               pal_re;
	logic [PAL_AW-1:0]  pal_raddr;
	logic [PAL_DW-1:0]  pal_rdata;
	stat_t              stat;

	assign pix_in.ready = in_ready;
	assign fire         = pix_in.valid && in_ready;

	bpsd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bpsd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.kind          (pix_in.kind),
		.data_byte     (pix_in.data_byte),
		.palette_index (pix_in.palette_index),
		.palette_word  (pix_in.palette_word),
		.cfg           (cfg),
		.px_valid      (px_valid),
		.px            (px),
		.pal_we        (pal_we),
		.pal_waddr     (pal_waddr),
		.pal_wdata     (pal_wdata),
		.pal_re        (pal_re),
		.pal_raddr     (pal_raddr),
		.stat          (stat)
	);

	bpsd_ram #(
		.WIDTH (PAL_DW),
		.DEPTH (PAL_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_waddr),
		.wdata (pal_wdata),
		.re    (pal_re),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	bpsd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.px_valid  (px_valid),
		.px        (px),
		.pal_rdata (pal_rdata),
		.in_ready  (in_ready),
		.s1_busy   (s1_busy),
		.pix_out   (pix_out)
	);

	// Both stages full and the sink stalled: no input may be taken.
	`BPSD_ASSERT_SAME(a_full_blocks_in, clk, arst_n, s1_busy && pix_out.valid && !pix_out.ready, !pix_in.ready, "input taken while both pixel stages full")
	// Last pixel of the image locks out further pixel bytes.
	`BPSD_ASSERT_NEXT(a_last_sets_done, clk, arst_n, px_valid && px.pix.frame_done, stat.finished, "finished flag not set after last pixel")
	`BPSD_ASSERT_SAME(a_no_px_when_done, clk, arst_n, stat.finished, !px_valid, "pixel produced after image finished")

endmodule

`default_nettype wire
